// ===== sv/dtoi_pkg.sv =====
// Shared types, constants and character codes for the decimal text to integer unit.
// No dependencies; every other file of the block imports this package.
package dtoi_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int SUM_WIDTH = VALUE_WIDTH + 4;
   localparam int DATA_WIDTH = 64;
   localparam int CHAR_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 8;

   localparam logic [DATA_WIDTH-1:0] VALUE_MASK = {DATA_WIDTH{1'b1}} >> (DATA_WIDTH - VALUE_WIDTH);
   localparam logic [DATA_WIDTH-1:0] LIMIT_DEFAULT = 64'd2147483647;
   localparam logic [DATA_WIDTH-1:0] LIMIT_RESET_WIDE =
      (LIMIT_DEFAULT > VALUE_MASK) ? VALUE_MASK : LIMIT_DEFAULT;
   localparam logic [VALUE_WIDTH-1:0] LIMIT_POS_RESET = LIMIT_RESET_WIDE[VALUE_WIDTH-1:0];
   localparam logic [VALUE_WIDTH-1:0] LIMIT_NEG_RESET =
      (LIMIT_POS_RESET == VALUE_MASK[VALUE_WIDTH-1:0]) ? LIMIT_POS_RESET
                                                       : LIMIT_POS_RESET + 1'b1;

   localparam logic [CHAR_WIDTH-1:0] CHAR_END = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VALUE_LIMIT = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIGNED_MODE = 8'd1;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_DIGIT,
      STATUS_OVERFLOW
   } status_type;

   typedef enum logic [1:0] {
      KIND_DIGIT,
      KIND_SIGN,
      KIND_OTHER,
      KIND_END
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [3:0] digit;
   } item_type;

   typedef struct packed {
      logic valid;
      item_type item;
   } head_type;

endpackage

// ===== sv/dtoi_if.sv =====
// Valid/ready channel interfaces for the character input and the result output.
// Depends on dtoi_pkg for the field widths.
interface dtoi_req_if;
   import dtoi_pkg::*;
   logic valid;
   logic ready;
   logic [CHAR_WIDTH-1:0] char_code;
   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface dtoi_rsp_if;
   import dtoi_pkg::*;
   logic valid;
   logic ready;
   logic [DATA_WIDTH-1:0] value_bits;
   logic [1:0] status;
   modport source (output valid, output value_bits, output status, input ready);
   modport sink (input valid, input value_bits, input status, output ready);
endinterface

// ===== sv/dtoi_front.sv =====
// Front end: accepts characters and classifies them into digit, sign, other or end.
// Depends on dtoi_pkg and dtoi_req_if.
module dtoi_front
   import dtoi_pkg::*;
(
   input  logic clock,
   input  logic reset,
   dtoi_req_if.sink req_ch,
   input  logic signed_mode,
   input  logic queue_full,
   output logic push,
   output item_type item
);

   logic at_start_ff;
   logic at_start_in;
   logic [CHAR_WIDTH-1:0] code;

   assign code = req_ch.char_code;
   assign req_ch.ready = !queue_full;
   assign push = req_ch.valid && !queue_full;

   always_comb begin
      item.digit = 4'(code - CHAR_ZERO);
      if (code == CHAR_END) begin
         item.kind = KIND_END;
      end else if (at_start_ff && signed_mode && code == CHAR_MINUS) begin
         item.kind = KIND_SIGN;
      end else if (code inside {[CHAR_ZERO:CHAR_NINE]}) begin
         item.kind = KIND_DIGIT;
      end else begin
         item.kind = KIND_OTHER;
      end
      at_start_in = push ? (item.kind == KIND_END) : at_start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
      end else begin
         at_start_ff <= at_start_in;
      end
   end

endmodule

// ===== sv/dtoi_queue.sv =====
// Two-entry queue of classified items between the front end and the back end.
// Depends on dtoi_pkg.
module dtoi_queue
   import dtoi_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  item_type push_item,
   input  logic pop,
   output head_type head,
   output logic full
);

   item_type entry_ff [2];
   logic wr_ptr_ff;
   logic rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign head.valid = (count_ff != 2'd0);
   assign head.item = entry_ff[rd_ptr_ff];
   assign full = (count_ff == 2'd2);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/dtoi_back.sv =====
// Back end: runs the accumulate and limit check per item and holds the result register.
// Depends on dtoi_pkg and dtoi_rsp_if.
module dtoi_back
   import dtoi_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  head_type head,
   input  logic [VALUE_WIDTH-1:0] limit_pos,
   input  logic [VALUE_WIDTH-1:0] limit_neg,
   output logic pop,
   dtoi_rsp_if.source rsp_ch
);

   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic neg_ff, neg_in;
   logic seen_ff, seen_in;
   status_type err_ff, err_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   status_type status_ff, status_in;

   logic out_free;
   logic [SUM_WIDTH-1:0] acc_wide;
   logic [SUM_WIDTH-1:0] sum;
   logic [VALUE_WIDTH-1:0] limit;
   status_type final_status;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign pop = head.valid && (head.item.kind != KIND_END || out_free);
   assign acc_wide = SUM_WIDTH'(acc_ff);
   assign sum = (acc_wide << 3) + (acc_wide << 1) + SUM_WIDTH'(head.item.digit);
   assign limit = neg_ff ? limit_neg : limit_pos;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.value_bits = value_ff;
   assign rsp_ch.status = status_ff;

   always_comb begin
      acc_in = acc_ff;
      neg_in = neg_ff;
      seen_in = seen_ff;
      err_in = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      value_in = value_ff;
      status_in = status_ff;
      final_status = (err_ff == STATUS_OK && !seen_ff) ? STATUS_DIGIT : err_ff;
      if (pop) begin
         case (head.item.kind)
            KIND_END: begin
               rsp_valid_in = 1'b1;
               status_in = final_status;
               if (final_status == STATUS_OK) begin
                  value_in = DATA_WIDTH'(neg_ff ? (VALUE_WIDTH'(0) - acc_ff) : acc_ff);
               end else begin
                  value_in = '0;
               end
               acc_in = '0;
               neg_in = 1'b0;
               seen_in = 1'b0;
               err_in = STATUS_OK;
            end
            KIND_SIGN: begin
               if (err_ff == STATUS_OK) begin
                  neg_in = 1'b1;
               end
            end
            KIND_DIGIT: begin
               if (err_ff == STATUS_OK) begin
                  if (sum > SUM_WIDTH'(limit)) begin
                     err_in = STATUS_OVERFLOW;
                  end else begin
                     acc_in = sum[VALUE_WIDTH-1:0];
                     seen_in = 1'b1;
                  end
               end
            end
            default: begin
               if (err_ff == STATUS_OK) begin
                  err_in = STATUS_DIGIT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      status_ff <= status_in;
      if (reset) begin
         acc_ff <= '0;
         neg_ff <= 1'b0;
         seen_ff <= 1'b0;
         err_ff <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         neg_ff <= neg_in;
         seen_ff <= seen_in;
         err_ff <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/decimal_text_to_integer_unit.sv =====
// Top level of the decimal text to integer unit: configuration registers and wiring.
// Depends on dtoi_pkg, dtoi_if, dtoi_front, dtoi_queue and dtoi_back.
//
// The unit takes one character per cycle while the queue is not full and gives one
// result per zero terminator, held in a queue entry and then in the result register.
// The sustained rate is one item per cycle unless a terminator waits on a stalled
// result; it is set by the back end, which does one multiply-by-ten add and one limit
// compare per item, and by the output register that holds a result as input flows.
module decimal_text_to_integer_unit
   import dtoi_pkg::*;
(
   input  logic clock,
   input  logic reset,
   dtoi_req_if.sink req_ch,
   dtoi_rsp_if.source rsp_ch,
   input  logic csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0] csr_write_data
);

   logic [VALUE_WIDTH-1:0] limit_pos_ff, limit_pos_in;
   logic [VALUE_WIDTH-1:0] limit_neg_ff, limit_neg_in;
   logic signed_mode_ff, signed_mode_in;
   logic [VALUE_WIDTH-1:0] clipped;

   logic push;
   logic pop;
   logic queue_full;
   item_type push_item;
   head_type head;

   always_comb begin
      clipped = (csr_write_data > VALUE_MASK) ? VALUE_MASK[VALUE_WIDTH-1:0]
                                              : csr_write_data[VALUE_WIDTH-1:0];
      limit_pos_in = limit_pos_ff;
      limit_neg_in = limit_neg_ff;
      signed_mode_in = signed_mode_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_VALUE_LIMIT: begin
               limit_pos_in = clipped;
               limit_neg_in = (clipped == VALUE_MASK[VALUE_WIDTH-1:0]) ? clipped
                                                                      : clipped + 1'b1;
            end
            CSR_SIGNED_MODE: begin
               signed_mode_in = csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_pos_ff <= LIMIT_POS_RESET;
         limit_neg_ff <= LIMIT_NEG_RESET;
         signed_mode_ff <= 1'b1;
      end else begin
         limit_pos_ff <= limit_pos_in;
         limit_neg_ff <= limit_neg_in;
         signed_mode_ff <= signed_mode_in;
      end
   end

   dtoi_front u_front (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .signed_mode(signed_mode_ff),
      .queue_full(queue_full),
      .push(push),
      .item(push_item)
   );

   dtoi_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_item(push_item),
      .pop(pop),
      .head(head),
      .full(queue_full)
   );

   dtoi_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .limit_pos(limit_pos_ff),
      .limit_neg(limit_neg_ff),
      .pop(pop),
      .rsp_ch(rsp_ch)
   );

endmodule

// ===== sv/dtoi_checker.sv =====
// Port-level checks on the result channel of the decimal text to integer unit.
// Depends on dtoi_pkg; bound to decimal_text_to_integer_unit at the end of this file.
module dtoi_checker
   import dtoi_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_value_bits,
   input logic [1:0] rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_DIGIT ||
                     rsp_status == STATUS_OVERFLOW))
      else $error("result status holds an unused code");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_value_bits == '0)
      else $error("failed result carries a nonzero value");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind decimal_text_to_integer_unit dtoi_checker u_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_value_bits(rsp_ch.value_bits),
   .rsp_status(rsp_ch.status)
);
